/* sv/owm_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and types of the one-wire bus master.
package owm_pkg;

    localparam int OWM_BITS_PER_BYTE = 8;
    localparam int TICK_W            = 10;
    localparam int CFG_IDX_W         = 3;

    typedef logic [TICK_W-1:0] t_ticks;

    // Request codes
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_RESET = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_SAMPLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_PULSE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_SLOT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_REC    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL    = 3'd7;

    // Reset values of the timing registers, in microsecond ticks
    localparam t_ticks RST_RESET_LOW   = 10'd500;
    localparam t_ticks RST_PRES_SAMPLE = 10'd60;
    localparam t_ticks RST_RESET_TAIL  = 10'd470;
    localparam t_ticks RST_START_PULSE = 10'd1;
    localparam t_ticks RST_WRITE_SLOT  = 10'd60;
    localparam t_ticks RST_WRITE_REC   = 10'd5;
    localparam t_ticks RST_READ_SAMPLE = 10'd14;
    localparam t_ticks RST_READ_TAIL   = 10'd45;

    // Sequencer phase codes
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_RLOW    = 4'd1;
    localparam logic [3:0] PH_RWAIT   = 4'd2;
    localparam logic [3:0] PH_RTAIL   = 4'd3;
    localparam logic [3:0] PH_WSTART  = 4'd4;
    localparam logic [3:0] PH_WHOLD   = 4'd5;
    localparam logic [3:0] PH_WREC    = 4'd6;
    localparam logic [3:0] PH_RDSTART = 4'd7;
    localparam logic [3:0] PH_RDWAIT  = 4'd8;
    localparam logic [3:0] PH_RDTAIL  = 4'd9;

    typedef struct packed {
        t_ticks reset_low;
        t_ticks pres_sample;
        t_ticks reset_tail;
        t_ticks start_pulse;
        t_ticks write_slot;
        t_ticks write_rec;
        t_ticks read_sample;
        t_ticks read_tail;
    } t_cfg;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       device_present;
        logic       rejected;
    } t_res;

endpackage

/* sv/owm_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
interface owm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, req_type, data_byte, line_level, input ready);
    modport sink   (input valid, req_type, data_byte, line_level, output ready);
endinterface

interface owm_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       device_present;
    logic       rejected;

    modport source (output valid, drive_low, busy_res, done_res, read_data,
                    device_present, rejected, input ready);
    modport sink   (input valid, drive_low, busy_res, done_res, read_data,
                    device_present, rejected, output ready);
endinterface

/* sv/owm_cfg.sv */
`timescale 1ns / 1ps
// Timing configuration register file.
module owm_cfg
    import owm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  t_ticks               i_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low   <= RST_RESET_LOW;
            r_cfg.pres_sample <= RST_PRES_SAMPLE;
            r_cfg.reset_tail  <= RST_RESET_TAIL;
            r_cfg.start_pulse <= RST_START_PULSE;
            r_cfg.write_slot  <= RST_WRITE_SLOT;
            r_cfg.write_rec   <= RST_WRITE_REC;
            r_cfg.read_sample <= RST_READ_SAMPLE;
            r_cfg.read_tail   <= RST_READ_TAIL;
        end else if (i_wr_en) begin
            case (i_idx)
                CFG_RESET_LOW:   r_cfg.reset_low   <= i_wdata;
                CFG_PRES_SAMPLE: r_cfg.pres_sample <= i_wdata;
                CFG_RESET_TAIL:  r_cfg.reset_tail  <= i_wdata;
                CFG_START_PULSE: r_cfg.start_pulse <= i_wdata;
                CFG_WRITE_SLOT:  r_cfg.write_slot  <= i_wdata;
                CFG_WRITE_REC:   r_cfg.write_rec   <= i_wdata;
                CFG_READ_SAMPLE: r_cfg.read_sample <= i_wdata;
                CFG_READ_TAIL:   r_cfg.read_tail   <= i_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* sv/owm_step.sv */
`timescale 1ns / 1ps
// Bus sequencer state and the per-item update that forms one result.
module owm_step
    import owm_pkg::*;
#(
    parameter int BITS_PER_BYTE = OWM_BITS_PER_BYTE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_data_byte,
    input  logic       i_line_level,
    input  t_cfg       i_cfg,
    output t_res       o_res
);

    localparam int BIT_W = $clog2(BITS_PER_BYTE + 1);
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BITS_PER_BYTE);

    logic [3:0]       r_phase,    n_phase;
    t_ticks           r_tick,     n_tick;
    logic [BIT_W-1:0] r_bit,      n_bit;
    logic [7:0]       r_shift,    n_shift;
    logic             r_presence, n_presence;
    logic [7:0]       r_last_rd,  n_last_rd;

    t_ticks           w_len_raw;
    t_ticks           w_len;
    logic [TICK_W:0]  w_tick_inc;
    logic             w_hit;
    logic [BIT_W-1:0] w_bit_inc;
    logic             w_bits_done;
    logic [7:0]       w_cur_shift;
    logic             w_done;
    logic             w_rej;
    logic             w_drive;

    // Length of the running phase; a zero register still lasts one tick
    always_comb begin
        case (r_phase)
            PH_RLOW:    w_len_raw = i_cfg.reset_low;
            PH_RWAIT:   w_len_raw = i_cfg.pres_sample;
            PH_RTAIL:   w_len_raw = i_cfg.reset_tail;
            PH_WSTART:  w_len_raw = i_cfg.start_pulse;
            PH_RDSTART: w_len_raw = i_cfg.start_pulse;
            PH_WHOLD:   w_len_raw = i_cfg.write_slot;
            PH_WREC:    w_len_raw = i_cfg.write_rec;
            PH_RDWAIT:  w_len_raw = i_cfg.read_sample;
            PH_RDTAIL:  w_len_raw = i_cfg.read_tail;
            default:    w_len_raw = t_ticks'(1);
        endcase
        w_len = (w_len_raw == '0) ? t_ticks'(1) : w_len_raw;
    end

    assign w_tick_inc  = {1'b0, r_tick} + (TICK_W+1)'(1);
    assign w_hit       = w_tick_inc >= {1'b0, w_len};
    assign w_bit_inc   = r_bit + BIT_W'(1);
    assign w_bits_done = w_bit_inc >= LAST_BIT;

    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_presence = r_presence;
        n_last_rd  = r_last_rd;
        w_done     = 1'b0;
        w_rej      = 1'b0;
        if (i_req_type == REQ_TICK) begin
            if (r_phase != PH_IDLE) begin
                if (!w_hit) begin
                    n_tick = w_tick_inc[TICK_W-1:0];
                end else begin
                    n_tick = '0;
                    case (r_phase)
                        PH_RLOW:  n_phase = PH_RWAIT;
                        PH_RWAIT: begin
                            n_presence = ~i_line_level;
                            n_phase    = PH_RTAIL;
                        end
                        PH_RTAIL: begin
                            n_phase = PH_IDLE;
                            w_done  = 1'b1;
                        end
                        PH_WSTART: n_phase = PH_WHOLD;
                        PH_WHOLD:  n_phase = PH_WREC;
                        PH_WREC: begin
                            n_bit = w_bit_inc;
                            if (w_bits_done) begin
                                n_phase = PH_IDLE;
                                w_done  = 1'b1;
                            end else begin
                                n_phase = PH_WSTART;
                            end
                        end
                        PH_RDSTART: n_phase = PH_RDWAIT;
                        PH_RDWAIT: begin
                            n_shift = r_shift | ({7'b0, i_line_level} << r_bit);
                            n_phase = PH_RDTAIL;
                        end
                        PH_RDTAIL: begin
                            n_bit = w_bit_inc;
                            if (w_bits_done) begin
                                n_last_rd = r_shift;
                                n_phase   = PH_IDLE;
                                w_done    = 1'b1;
                            end else begin
                                n_phase = PH_RDSTART;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
        end else if (r_phase != PH_IDLE) begin
            w_rej = 1'b1;
        end else begin
            n_tick = '0;
            n_bit  = '0;
            case (i_req_type)
                REQ_RESET: n_phase = PH_RLOW;
                REQ_WRITE: begin
                    n_shift = i_data_byte;
                    n_phase = PH_WSTART;
                end
                default: begin
                    n_shift = '0;
                    n_phase = PH_RDSTART;
                end
            endcase
        end
    end

    // Line drive follows the phase left by this item
    assign w_cur_shift = n_shift >> n_bit;

    always_comb begin
        case (n_phase)
            PH_RLOW, PH_WSTART, PH_RDSTART: w_drive = 1'b1;
            PH_WHOLD: w_drive = ~w_cur_shift[0];
            default:  w_drive = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_presence <= 1'b0;
            r_last_rd  <= '0;
        end else if (i_en) begin
            r_phase    <= n_phase;
            r_tick     <= n_tick;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_presence <= n_presence;
            r_last_rd  <= n_last_rd;
        end
    end

    assign o_res.drive_low      = w_drive;
    assign o_res.busy_res       = n_phase != PH_IDLE;
    assign o_res.done_res       = w_done;
    assign o_res.read_data      = n_last_rd;
    assign o_res.device_present = n_presence;
    assign o_res.rejected       = w_rej;

endmodule

/* sv/one_wire_bus_master.sv */
`timescale 1ns / 1ps
// Top level of the one-wire bus master: input register, sequencer, result register.
//
// Usage:
//   i_req carries one item per transfer: a tick (one microsecond gone, with the
//   sampled bus level) or a command (bus reset, write byte, read byte).
//   o_res returns one result per item: line drive, busy, done, last read byte,
//   presence flag and a reject flag for a command that arrived while busy.
//   The user must write the timing registers via i_cfg_wr_en / i_cfg_idx /
//   i_cfg_wdata only while no item is in flight; the block does not enforce it.
// Pipeline and throughput:
//   An accepted item waits in the input register, is stepped into the result
//   register when that stage advances, and its result is offered from there.
//   One item per cycle is sustained while o_res.ready stays high; the
//   sequencer update is a single registered pass.
// Reset:
//   i_rst_n low (synchronous) empties both stages, puts the sequencer idle
//   and loads the default timing values.
// Stall:
//   While a result waits and o_res.ready is low, it holds; an empty input
//   register still takes one item, then i_req.ready drops until the result moves.
module one_wire_bus_master
    import owm_pkg::*;
#(
    parameter int BITS_PER_BYTE = OWM_BITS_PER_BYTE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    owm_req_if.sink              i_req,
    owm_res_if.source            o_res,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_ticks               i_cfg_wdata
);

    // Input stage
    logic       r_in_valid;
    logic [1:0] r_in_req_type;
    logic [7:0] r_in_data_byte;
    logic       r_in_line_level;

    // Result stage
    logic       r_out_valid;
    t_res       r_out;

    logic       w_adv_out;
    logic       w_step_en;
    logic       w_in_ready;
    t_cfg       w_cfg;
    t_res       w_step_res;

    // Advance the result stage when it is empty or being taken
    assign w_adv_out  = !r_out_valid || o_res.ready;
    assign w_step_en  = r_in_valid && w_adv_out;
    assign w_in_ready = !r_in_valid || w_adv_out;

    assign i_req.ready = w_in_ready;

    owm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_wr_en),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    // Sequencer state commits only when its result moves into the result stage
    owm_step #(
        .BITS_PER_BYTE (BITS_PER_BYTE)
    ) u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_step_en),
        .i_req_type   (r_in_req_type),
        .i_data_byte  (r_in_data_byte),
        .i_line_level (r_in_line_level),
        .i_cfg        (w_cfg),
        .o_res        (w_step_res)
    );

    // Capture an item on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && w_in_ready) begin
            r_in_req_type   <= i_req.req_type;
            r_in_data_byte  <= i_req.data_byte;
            r_in_line_level <= i_req.line_level;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv_out) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step_en) begin
            r_out <= w_step_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.drive_low      = r_out.drive_low;
    assign o_res.busy_res       = r_out.busy_res;
    assign o_res.done_res       = r_out.done_res;
    assign o_res.read_data      = r_out.read_data;
    assign o_res.device_present = r_out.device_present;
    assign o_res.rejected       = r_out.rejected;

    // A completed operation leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res)
        else $error("done reported while still busy");

    // A rejected command never completes an operation
    a_rej_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rejected |-> !r_out.done_res)
        else $error("rejected item also reported done");

    // Idle master releases the line
    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.busy_res |-> !r_out.drive_low)
        else $error("line driven low while idle");

    // A rejected command can only come while an operation runs
    a_rej_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rejected |-> r_out.busy_res)
        else $error("command rejected while idle");

    // A stalled input item stays in the input stage
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv_out |=> r_in_valid)
        else $error("input item lost during stall");

endmodule
